>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks used by the checker module of the project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle during reset
`define CSP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, idle during reset
`define CSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/csp_pkg.sv
// ---------------------------------------------------------------------------
// csp_pkg
// Types and constants of the color sensor period capture block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package csp_pkg;

  localparam int unsigned CLK_W      = 27;
  localparam int unsigned VAL_W      = 16;
  localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(1000000);
  localparam logic [VAL_W-1:0] FREQ_MAX  = {VAL_W{1'b1}};

  // Color filter in front of the photodiodes
  typedef enum logic [1:0] {
    PH_RED   = 2'd0,
    PH_GREEN = 2'd1,
    PH_BLUE  = 2'd2
  } phase_t;

  // Capture sequencer
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_DIV   = 2'd1,
    ST_STORE = 2'd2,
    ST_OUT   = 2'd3
  } state_t;

  typedef struct packed {
    logic             on_channel_one;
    logic [VAL_W-1:0] captured_value;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] measured_frequency;
    logic [VAL_W-1:0] red_level;
    logic [VAL_W-1:0] green_level;
    logic [VAL_W-1:0] blue_level;
    logic             floor_is_red;
    logic             select_pin_one;
    logic             select_pin_two;
    logic             clear_timer;
  } out_item_t;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> rtl/color_sensor_period_capture.sv
// Flow: the second capture of a pair starts the bit-serial divider, one
//   step per reference clock bit; the result is then stored and output.
// Zero period skips the divider. Other-channel and first captures
//   are taken and give no result.
// No capture is taken after a pair's second one until its reading is loaded out.
// Reset: synchronous active-low rst_n clears state; clock rate back to 1 MHz.
// ---------------------------------------------------------------------------
// color_sensor_period_capture
// Pairs timer captures into a period, turns it into a frequency, stores it
// per color filter, rotates the filter and reports the select pin levels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module color_sensor_period_capture (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [csp_pkg::CLK_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  csp_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output csp_pkg::out_item_t        out_data
);
  import csp_pkg::*;

  state_t           state_r;
  state_t           state_nxt;
  phase_t           phase_r;
  logic [CLK_W-1:0] ref_clk_r;
  logic             have_first_r;
  logic [VAL_W-1:0] first_val_r;
  logic [VAL_W-1:0] red_r;
  logic [VAL_W-1:0] green_r;
  logic [VAL_W-1:0] blue_r;
  logic [VAL_W-1:0] freq_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             in_acc;
  logic             pair_done;
  logic [VAL_W-1:0] period;
  logic             zero_period;
  logic             div_start;
  logic             store_en;
  logic             out_load;
  logic             floor_red;
  logic [VAL_W+1:0] red2;
  logic [VAL_W+1:0] green3;
  logic [VAL_W+1:0] blue3;
  div_status_t      div_stat;
  logic [VAL_W-1:0] div_quo;

  // Decode the incoming item
  assign in_acc      = in_valid && in_ready;
  assign pair_done   = in_acc && in_data.on_channel_one && have_first_r;
  assign period      = in_data.captured_value - first_val_r;
  assign zero_period = (period == '0);

  csp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ref_clk_r),
    .divisor  (period),
    .status   (div_stat),
    .quotient (div_quo)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pair_done) begin
          state_nxt = zero_period ? ST_STORE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    store_en  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        div_start = pair_done && !zero_period;
      end
      ST_DIV: begin
      end
      ST_STORE: begin
        store_en = 1'b1;
      end
      ST_OUT: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
      end
    endcase
  end

  // Floor test: red*2 against green*3 and blue*3
  always_comb begin
    red2      = {1'b0, red_r, 1'b0};
    green3    = {1'b0, green_r, 1'b0} + {2'b00, green_r};
    blue3     = {1'b0, blue_r, 1'b0} + {2'b00, blue_r};
    floor_red = (red2 >= green3) && (red2 >= blue3);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_RED;
      ref_clk_r    <= CLK_RESET;
      have_first_r <= 1'b0;
      first_val_r  <= '0;
      red_r        <= '0;
      green_r      <= '0;
      blue_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        ref_clk_r <= cfg_wr_data;
      end
      // hold first capture of a pair, drop the pair once its second arrives
      if (in_acc && in_data.on_channel_one) begin
        if (have_first_r) begin
          have_first_r <= 1'b0;
        end else begin
          have_first_r <= 1'b1;
          first_val_r  <= in_data.captured_value;
        end
      end
      // store frequency under the current filter, advance the filter
      if (store_en) begin
        case (phase_r)
          PH_GREEN: begin
            green_r <= freq_r;
            phase_r <= PH_BLUE;
          end
          PH_BLUE: begin
            blue_r  <= freq_r;
            phase_r <= PH_RED;
          end
          default: begin
            red_r   <= freq_r;
            phase_r <= PH_GREEN;
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Frequency capture and output item
  always_ff @(posedge clk) begin
    if (pair_done && zero_period) begin
      freq_r <= FREQ_MAX;
    end else if (div_stat.done) begin
      freq_r <= div_quo;
    end
    if (out_load) begin
      out_data_r.measured_frequency <= freq_r;
      out_data_r.red_level          <= red_r;
      out_data_r.green_level        <= green_r;
      out_data_r.blue_level         <= blue_r;
      out_data_r.floor_is_red       <= floor_red;
      out_data_r.select_pin_one     <= (phase_r == PH_GREEN);
      out_data_r.select_pin_two     <= (phase_r == PH_GREEN) || (phase_r == PH_BLUE);
      out_data_r.clear_timer        <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/csp_div.sv
// ---------------------------------------------------------------------------
// csp_div
// Bit-serial restoring divider: reference clock over period, one quotient
// bit per cycle, result saturated to the 16-bit frequency range.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module csp_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [csp_pkg::CLK_W-1:0] dividend,
  input  logic [csp_pkg::VAL_W-1:0] divisor,
  output csp_pkg::div_status_t      status,
  output logic [csp_pkg::VAL_W-1:0] quotient
);
  import csp_pkg::*;

  localparam int unsigned CNT_W = $clog2(CLK_W);
  localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(CLK_W - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CLK_W-1:0] dvd_r;
  logic [VAL_W-1:0] rem_r;
  logic [VAL_W-1:0] quo_r;
  logic             ovf_r;
  logic [VAL_W-1:0] dsr_r;

  logic [VAL_W:0]   trial;
  logic [VAL_W:0]   diff;
  logic             qbit;
  logic [VAL_W-1:0] rem_nxt;

  // One restoring step: bring down the next dividend bit, try the subtract
  always_comb begin
    trial   = {rem_r, dvd_r[CLK_W-1]};
    diff    = trial - {1'b0, dsr_r};
    qbit    = (trial >= {1'b0, dsr_r});
    rem_nxt = qbit ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_INIT;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift datapath; quotient bits beyond 16 only mark overflow
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[CLK_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[VAL_W-2:0], qbit};
      ovf_r <= ovf_r | quo_r[VAL_W-1];
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = ovf_r ? FREQ_MAX : quo_r;

endmodule

>>> rtl/csp_checker.sv
// ---------------------------------------------------------------------------
// csp_checker
// Port-level checks of the color sensor period capture block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module csp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input csp_pkg::out_item_t out_data
);
  import csp_pkg::*;

  logic [VAL_W+1:0] red2;
  logic [VAL_W+1:0] green3;
  logic [VAL_W+1:0] blue3;
  logic             floor_ok;
  logic             pins_ok;

  // Recompute the floor test from the reported levels
  always_comb begin
    red2     = {1'b0, out_data.red_level, 1'b0};
    green3   = {1'b0, out_data.green_level, 1'b0} + {2'b00, out_data.green_level};
    blue3    = {1'b0, out_data.blue_level, 1'b0} + {2'b00, out_data.blue_level};
    floor_ok = (out_data.floor_is_red == ((red2 >= green3) && (red2 >= blue3)));
    pins_ok  = !(out_data.select_pin_one && !out_data.select_pin_two);
  end

  `CSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `CSP_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data))
  `CSP_ASSERT_IMP(a_floor, clk, rst_n, out_valid, floor_ok)
  `CSP_ASSERT_IMP(a_pins, clk, rst_n, out_valid, pins_ok)
  `CSP_ASSERT_IMP(a_clear, clk, rst_n, out_valid, out_data.clear_timer)

endmodule

bind color_sensor_period_capture csp_checker u_csp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> verif/color_sensor_period_capture_tb.sv
// ---------------------------------------------------------------------------
// color_sensor_period_capture_tb
// Drives timer capture items into the period capture block. A scoreboard
// keeps its own copy of the edge pairing, the per-filter levels and the
// filter rotation, and checks every reading field by field. Covers directed
// corner cases, several tick rates and random traffic with random stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module color_sensor_period_capture_tb;
  import csp_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS   = 330;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [CLK_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;

  // Captures waiting to go out, readings still owed by the block
  in_item_t  capture_backlog[$];
  out_item_t expected_readings[$];

  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned captures_taken = 0;
  int unsigned readings_checked = 0;
  int unsigned rates_tried = 0;
  int unsigned fail_count = 0;

  // Scoreboard copy of the block state
  logic [CLK_W-1:0] tick_rate = CLK_RESET;
  logic             edge_held = 1'b0;
  logic [VAL_W-1:0] held_value = '0;
  phase_t           filter_sel = PH_RED;
  logic [VAL_W-1:0] lvl_red = '0;
  logic [VAL_W-1:0] lvl_green = '0;
  logic [VAL_W-1:0] lvl_blue = '0;

  color_sensor_period_capture u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  always #2 clk = ~clk;

  // Pair captures, turn the period into a frequency and rotate the filter
  function automatic void predict_reading(input in_item_t cap);
    logic [VAL_W-1:0] period;
    logic [VAL_W-1:0] freq;
    int unsigned      quot;
    out_item_t        rd;
    if (!cap.on_channel_one) return;
    if (!edge_held) begin
      held_value = cap.captured_value;
      edge_held  = 1'b1;
      return;
    end
    period = cap.captured_value - held_value;
    if (period == '0) begin
      freq = FREQ_MAX;
    end else begin
      quot = tick_rate / period;
      freq = (quot > FREQ_MAX) ? FREQ_MAX : quot[VAL_W-1:0];
    end
    case (filter_sel)
      PH_GREEN: begin
        lvl_green  = freq;
        filter_sel = PH_BLUE;
      end
      PH_BLUE: begin
        lvl_blue   = freq;
        filter_sel = PH_RED;
      end
      default: begin
        lvl_red    = freq;
        filter_sel = PH_GREEN;
      end
    endcase
    edge_held = 1'b0;
    rd.measured_frequency = freq;
    rd.red_level          = lvl_red;
    rd.green_level        = lvl_green;
    rd.blue_level         = lvl_blue;
    rd.floor_is_red       = (32'(lvl_red) * 2 >= 32'(lvl_green) * 3) &&
                            (32'(lvl_red) * 2 >= 32'(lvl_blue) * 3);
    rd.select_pin_one     = (filter_sel == PH_GREEN);
    rd.select_pin_two     = (filter_sel != PH_RED);
    rd.clear_timer        = 1'b1;
    expected_readings.push_back(rd);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void push_capture(input bit chan, input logic [VAL_W-1:0] value);
    in_item_t cap;
    cap.on_channel_one = chan;
    cap.captured_value = value;
    capture_backlog.push_back(cap);
  endfunction

  function automatic void push_pair(input logic [VAL_W-1:0] first,
                                    input logic [VAL_W-1:0] period);
    push_capture(1'b1, first);
    push_capture(1'b1, first + period);
  endfunction

  // Mostly a band near the useful range, with edge periods and a wide spread
  function automatic logic [VAL_W-1:0] pick_period();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return VAL_W'($urandom_range(0, 2));
      1:       return VAL_W'(16'hFFFF - $urandom_range(0, 3));
      2, 3, 4: return VAL_W'($urandom_range(1, 65535));
      default: return VAL_W'($urandom_range(8, 4000));
    endcase
  endfunction

  // Queue random traffic: mostly pairs, some noise and lone captures
  function automatic void add_random_captures(input int unsigned count);
    int unsigned done_cnt;
    int unsigned pick;
    logic [VAL_W-1:0] first;
    done_cnt = 0;
    while (done_cnt < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        push_capture(1'b0, VAL_W'($urandom()));
      end else if (pick < 12) begin
        push_capture(1'b1, VAL_W'($urandom()));
        done_cnt++;
      end else begin
        first = VAL_W'($urandom());
        push_capture(1'b1, first);
        if (pick < 16) push_capture(1'b0, VAL_W'($urandom()));
        push_capture(1'b1, first + pick_period());
        done_cnt += 2;
      end
    end
  endfunction

  // Wait until everything is sent and answered, then let the block go quiet
  task automatic settle();
    while (capture_backlog.size() != 0 || in_valid || expected_readings.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_tick_rate(input logic [CLK_W-1:0] rate);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rate;
    tick_rate = rate;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rates_tried++;
  endtask

  // Driver: hold the item until taken, then load the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_reading(in_data);
        captures_taken++;
      end
      if (capture_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        in_data  <= capture_backlog.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each taken reading with the oldest one owed
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          $error("reading with none expected: frequency %0d",
                 out_data.measured_frequency);
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          check_field("measured_frequency", want.measured_frequency,
                      out_data.measured_frequency);
          check_field("red_level", want.red_level, out_data.red_level);
          check_field("green_level", want.green_level, out_data.green_level);
          check_field("blue_level", want.blue_level, out_data.blue_level);
          check_field("floor_is_red", want.floor_is_red, out_data.floor_is_red);
          check_field("select_pin_one", want.select_pin_one, out_data.select_pin_one);
          check_field("select_pin_two", want.select_pin_two, out_data.select_pin_two);
          check_field("clear_timer", want.clear_timer, out_data.clear_timer);
          readings_checked++;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Stimulus sequence
  initial begin
    logic [CLK_W-1:0] rate_list [6];
    rate_list[0] = CLK_RESET;
    rate_list[1] = CLK_W'(1);
    rate_list[2] = CLK_W'(100000000);
    rate_list[3] = CLK_W'($urandom_range(1, 100000000));
    rate_list[4] = {CLK_W{1'b1}};
    rate_list[5] = CLK_W'(48000000);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    send_gap_pct   = 20;
    recv_stall_pct = 53;

    // Corner cases at the reset tick rate
    push_capture(1'b0, 16'hFFFF);          // other channel, ignored
    push_pair(16'h0000, 16'h0000);         // zero period
    push_pair(16'hFFFF, 16'h0001);         // wraps, saturates
    push_pair(16'h0000, 16'hFFFF);         // longest period
    push_capture(1'b1, 16'd100);
    push_capture(1'b0, 16'd5);             // noise inside a pair
    push_capture(1'b1, 16'd1100);
    push_pair(16'h7FF8, 16'd16);           // just under saturation
    push_pair(16'h1000, 16'hFFFF);         // wrapped long period
    settle();

    // Zero tick rate
    set_tick_rate('0);
    push_pair(16'd10, 16'd10);
    push_pair(16'd5, 16'd0);
    settle();

    // Largest tick rate
    set_tick_rate({CLK_W{1'b1}});
    push_pair(16'd0, 16'd1);
    push_pair(16'd0, 16'hFFFF);
    settle();

    // Smallest nonzero tick rate
    set_tick_rate(CLK_W'(1));
    push_pair(16'd0, 16'd1);
    push_pair(16'd0, 16'd2);
    settle();

    // Random traffic: receiver stalls first, then sender gaps, then none
    for (int i = 0; i < 6; i++) begin
      if (i < 2) begin
        send_gap_pct   = 20;
        recv_stall_pct = 53;
      end else if (i < 4) begin
        send_gap_pct   = 53;
        recv_stall_pct = 20;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      set_tick_rate(rate_list[i]);
      add_random_captures(PHASE_ITEMS);
      settle();
    end

    $display("Run covered %0d captures, %0d readings checked, %0d tick rates written",
             captures_taken, readings_checked, rates_tried);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
